### hw/rtl/lcs_pkg.sv
// Shared types and constants for the longest common substring length block.
// No dependencies; used by lcs_cell and longest_common_substring_length.
package lcs_pkg;

  localparam logic       FUNC_FIRST  = 1'b0;
  localparam logic       FUNC_SECOND = 1'b1;
  localparam logic [8:0] LEN_MAX     = 9'd511;

  typedef struct packed {
    logic       func;
    logic [7:0] symbol;
    logic       last_symbol;
  } in_word_t;

  typedef struct packed {
    logic [8:0] longest_length;
    logic       overflow;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       clear;
    logic [7:0] symbol;
  } cell_ctrl_t;

endpackage

### hw/rtl/longest_common_substring_length.sv
// Top level of the longest common substring length block: control, row of
// lcs_cell instances and result register. Depends on lcs_pkg and lcs_cell.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------
//  input    | start, busy, request   | word taken when start && !busy
//  result   | done, result           | one-cycle strobe, no back-pressure
//
// A first-string word fills the next free cell, or sets overflow if the row
// is full; a second-string word updates every stored position together in
// the cell row. The final word of the second string holds busy while the
// running maximum ripples down the row; the result follows and all state
// clears for the next pair. Reset is synchronous and leaves it idle and empty.
module longest_common_substring_length #(
  parameter int MAX_LEN = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lcs_pkg::in_word_t request,
  output logic              done,
  output lcs_pkg::out_word_t result
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int RW = CW;
  localparam int WW = (RW > 9) ? RW : 9;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] dcnt;
  logic          overflow_seen;
  logic          accept;
  logic          full;
  logic          emit;
  logic [WW-1:0] best_ext;
  logic [8:0]    best_sat;

  lcs_pkg::cell_ctrl_t ctrl;

  logic [RW-1:0] run_w [MAX_LEN];
  logic [RW-1:0] max_w [MAX_LEN];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(MAX_LEN));
  assign emit   = (state == ST_DRAIN) && (dcnt == CW'(MAX_LEN));

  assign ctrl.load   = accept && (request.func == lcs_pkg::FUNC_FIRST) && !full;
  assign ctrl.step   = accept && (request.func == lcs_pkg::FUNC_SECOND);
  assign ctrl.clear  = emit;
  assign ctrl.symbol = request.symbol;

  assign best_ext = WW'(max_w[MAX_LEN-1]);
  assign best_sat = (best_ext > WW'(lcs_pkg::LEN_MAX)) ? lcs_pkg::LEN_MAX : best_ext[8:0];

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_row
    logic [RW-1:0] run_left;
    logic [RW-1:0] max_left;
    if (i == 0) begin : g_head
      assign run_left = '0;
      assign max_left = '0;
    end else begin : g_link
      assign run_left = run_w[i-1];
      assign max_left = max_w[i-1];
    end
    lcs_cell #(
      .RW(RW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sel     (count == CW'(i)),
      .run_in  (run_left),
      .max_in  (max_left),
      .run_out (run_w[i]),
      .max_out (max_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      dcnt          <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= emit;
      case (state)
        ST_IDLE: begin
          if (ctrl.load) begin
            count <= count + 1'b1;
          end
          if (accept && (request.func == lcs_pkg::FUNC_FIRST) && full) begin
            overflow_seen <= 1'b1;
          end
          if (ctrl.step && request.last_symbol) begin
            state <= ST_DRAIN;
            dcnt  <= '0;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            state         <= ST_IDLE;
            count         <= '0;
            overflow_seen <= 1'b0;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.longest_length <= best_sat;
      result.overflow       <= overflow_seen;
    end
  end

endmodule

### hw/rtl/lcs_cell.sv
// One stored position of the first string: symbol, run length, local best and
// a running maximum passed along the row. Depends on lcs_pkg.
module lcs_cell #(
  parameter int RW = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  lcs_pkg::cell_ctrl_t ctrl,
  input  logic              sel,
  input  logic [RW-1:0]     run_in,
  input  logic [RW-1:0]     max_in,
  output logic [RW-1:0]     run_out,
  output logic [RW-1:0]     max_out
);

  logic [7:0]    ch;
  logic          valid;
  logic [RW-1:0] run;
  logic [RW-1:0] best;
  logic [RW-1:0] chain;
  logic [RW-1:0] run_next;
  logic          hit;

  assign hit      = valid && (ch == ctrl.symbol);
  assign run_next = hit ? RW'(run_in + 1'b1) : '0;
  assign run_out  = run;
  assign max_out  = chain;

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      ch <= ctrl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
      run   <= '0;
      best  <= '0;
      chain <= '0;
    end else begin
      chain <= (max_in > best) ? max_in : best;
      if (ctrl.load && sel) begin
        valid <= 1'b1;
        run   <= '0;
      end else if (ctrl.step && valid) begin
        run <= run_next;
        if (run_next > best) begin
          best <= run_next;
        end
      end
    end
  end

endmodule
